[rtl/core/kwm_pkg.sv]
// Shared types, command codes and constants for the k-way merge min-heap core.
package kwm_pkg;

  // Default number of heap entries (merge ways).
  localparam int unsigned HEAP_WAYS_DEF = 16;

  // Field widths fixed by the word formats.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SOURCE_W = 4;

  // Command codes carried in an input word.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_REFILL = 2'd2,
    CMD_DROP   = 2'd3
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CARRY,
    ST_CMP,
    ST_WB,
    ST_FIN
  } state_e;

  // Input word.
  typedef struct packed {
    cmd_e                        cmd;
    logic signed [VALUE_W-1:0]   value;
    logic        [SOURCE_W-1:0]  source;
  } item_t;

  // Result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0]   top_value;
    logic        [SOURCE_W-1:0]  top_source;
    logic                        heap_empty;
  } result_t;

  // One heap entry as held in memory.
  typedef struct packed {
    logic signed [VALUE_W-1:0]   value;
    logic        [SOURCE_W-1:0]  source;
  } entry_t;

endpackage

[rtl/core/kwm_mem.sv]
// Heap entry store: one write port and two registered read ports.
module kwm_mem #(
  parameter int unsigned HEAP_WAYS = kwm_pkg::HEAP_WAYS_DEF,
  localparam int unsigned AW = $clog2(HEAP_WAYS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  kwm_pkg::entry_t      wdata_i,
  input  logic [AW-1:0]        rd_a_addr_i,
  input  logic [AW-1:0]        rd_b_addr_i,
  output kwm_pkg::entry_t      rd_a_data_o,
  output kwm_pkg::entry_t      rd_b_data_o
);

  kwm_pkg::entry_t mem_q [HEAP_WAYS];
  kwm_pkg::entry_t rd_a_q;
  kwm_pkg::entry_t rd_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two read ports, each registered.
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_a_addr_i];
    rd_b_q <= mem_q[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

[rtl/core/kwm_ctrl.sv]
// Command sequencer: load, build, refill and drop with a memory-based sift-down.
module kwm_ctrl #(
  parameter int unsigned HEAP_WAYS = kwm_pkg::HEAP_WAYS_DEF,
  localparam int unsigned AW = $clog2(HEAP_WAYS),
  localparam int unsigned CW = $clog2(HEAP_WAYS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  kwm_pkg::item_t       item_i,
  output logic                 result_valid_o,
  output kwm_pkg::result_t     result_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output kwm_pkg::entry_t      mem_wdata_o,
  output logic [AW-1:0]        mem_rd_a_addr_o,
  output logic [AW-1:0]        mem_rd_b_addr_o,
  input  kwm_pkg::entry_t      mem_rd_a_data_i,
  input  kwm_pkg::entry_t      mem_rd_b_data_i
);

  // Child index width: 2 * pos + 2 must fit.
  localparam int unsigned IW = AW + 2;

  kwm_pkg::state_e  state_q, state_d;
  kwm_pkg::cmd_e    cmd_q, cmd_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    bld_q, bld_d;
  logic [AW-1:0]    pos_q, pos_d;
  kwm_pkg::entry_t  carry_q, carry_d;
  kwm_pkg::entry_t  top_q, top_d;
  logic             res_valid_q, res_valid_d;
  kwm_pkg::result_t res_q, res_d;

  logic             accept;
  logic [CW-1:0]    half;
  logic [IW-1:0]    cnt_ext;
  logic [IW-1:0]    cur_left, cur_right;
  logic             cur_right_ok;
  logic             take_l, take_r, swap;
  logic signed [kwm_pkg::VALUE_W-1:0] best_val;
  kwm_pkg::entry_t  child;
  logic [AW-1:0]    best_pos;
  logic [AW-1:0]    probe_pos;
  logic [IW-1:0]    probe_left, probe_right;
  logic             probe_has_left, probe_has_right;

  assign accept  = start && !busy;
  assign half    = count_q >> 1;
  assign cnt_ext = IW'(count_q);

  // Children of the position whose children were read last cycle.
  assign cur_left     = {1'b0, pos_q, 1'b1};
  assign cur_right    = cur_left + IW'(1);
  assign cur_right_ok = cur_right < cnt_ext;

  // Pick the smallest of carry, left child and right child; carry wins ties, then left.
  always_comb begin
    take_l   = $signed(mem_rd_a_data_i.value) < $signed(carry_q.value);
    best_val = take_l ? mem_rd_a_data_i.value : carry_q.value;
    take_r   = cur_right_ok && ($signed(mem_rd_b_data_i.value) < $signed(best_val));
    swap     = take_l || take_r;
    child    = take_r ? mem_rd_b_data_i : mem_rd_a_data_i;
    best_pos = take_r ? cur_right[AW-1:0] : cur_left[AW-1:0];
  end

  // Position whose children are fetched in this cycle.
  always_comb begin
    unique case (state_q)
      kwm_pkg::ST_IDLE: probe_pos = '0;
      kwm_pkg::ST_CMP:  probe_pos = best_pos;
      default:          probe_pos = pos_q;
    endcase
  end

  assign probe_left      = {1'b0, probe_pos, 1'b1};
  assign probe_right     = probe_left + IW'(1);
  assign probe_has_left  = probe_left < cnt_ext;
  assign probe_has_right = probe_right < cnt_ext;

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kwm_pkg::ST_IDLE;
      cmd_q       <= kwm_pkg::CMD_LOAD;
      count_q     <= '0;
      bld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      count_q     <= count_d;
      bld_q       <= bld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    carry_q <= carry_d;
    top_q   <= top_d;
    res_q   <= res_d;
  end

  // Next state, memory requests and result.
  always_comb begin
    state_d         = state_q;
    cmd_d           = cmd_q;
    count_d         = count_q;
    bld_d           = bld_q;
    pos_d           = pos_q;
    carry_d         = carry_q;
    res_valid_d     = 1'b0;
    res_d           = res_q;
    mem_we_o        = 1'b0;
    mem_waddr_o     = pos_q;
    mem_wdata_o     = carry_q;
    mem_rd_a_addr_o = probe_left[AW-1:0];
    mem_rd_b_addr_o = probe_has_right ? probe_right[AW-1:0] : probe_left[AW-1:0];

    unique case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = item_i.cmd;
          unique case (item_i.cmd)
            kwm_pkg::CMD_LOAD: begin
              if (count_q < CW'(HEAP_WAYS)) begin
                mem_we_o           = 1'b1;
                mem_waddr_o        = count_q[AW-1:0];
                mem_wdata_o.value  = item_i.value;
                mem_wdata_o.source = item_i.source;
                count_d            = count_q + CW'(1);
              end
            end
            kwm_pkg::CMD_BUILD: begin
              if (half == '0) begin
                res_valid_d = 1'b1;
              end else begin
                pos_d           = AW'(half - CW'(1));
                bld_d           = half - CW'(1);
                mem_rd_a_addr_o = AW'(half - CW'(1));
                state_d         = kwm_pkg::ST_RD_CARRY;
              end
            end
            kwm_pkg::CMD_REFILL: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                carry_d.value  = item_i.value;
                carry_d.source = top_q.source;
                pos_d          = '0;
                if (probe_has_left) begin
                  state_d = kwm_pkg::ST_CMP;
                end else begin
                  // Single entry: the root is simply replaced.
                  mem_we_o    = 1'b1;
                  mem_waddr_o = '0;
                  mem_wdata_o = carry_d;
                  state_d     = kwm_pkg::ST_FIN;
                end
              end
            end
            kwm_pkg::CMD_DROP: begin
              count_d = (count_q == '0) ? count_q : count_q - CW'(1);
              if (count_d == '0) begin
                res_valid_d = 1'b1;
              end else begin
                // Fetch the last entry; it sifts down from the root.
                mem_rd_a_addr_o = AW'(count_q - CW'(1));
                pos_d           = '0;
                state_d         = kwm_pkg::ST_RD_CARRY;
              end
            end
            default: ;
          endcase
        end
      end

      kwm_pkg::ST_RD_CARRY: begin
        carry_d = mem_rd_a_data_i;
        if (probe_has_left) begin
          state_d = kwm_pkg::ST_CMP;
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rd_a_data_i;
          state_d     = kwm_pkg::ST_FIN;
        end
      end

      kwm_pkg::ST_CMP: begin
        mem_we_o = 1'b1;
        if (swap) begin
          // The smaller child moves up into the hole.
          mem_wdata_o = child;
          pos_d       = best_pos;
          state_d     = probe_has_left ? kwm_pkg::ST_CMP : kwm_pkg::ST_WB;
        end else begin
          state_d = kwm_pkg::ST_FIN;
        end
      end

      kwm_pkg::ST_WB: begin
        mem_we_o = 1'b1;
        state_d  = kwm_pkg::ST_FIN;
      end

      kwm_pkg::ST_FIN: begin
        if ((cmd_q == kwm_pkg::CMD_BUILD) && (bld_q != '0)) begin
          bld_d           = bld_q - CW'(1);
          pos_d           = AW'(bld_q - CW'(1));
          mem_rd_a_addr_o = AW'(bld_q - CW'(1));
          state_d         = kwm_pkg::ST_RD_CARRY;
        end else begin
          res_valid_d = 1'b1;
          state_d     = kwm_pkg::ST_IDLE;
        end
      end

      default: state_d = kwm_pkg::ST_IDLE;
    endcase

    // Result word from the root shadow.
    if (res_valid_d) begin
      res_d.heap_empty = (count_d == '0);
      res_d.top_value  = (count_d == '0) ? '0 : top_q.value;
      res_d.top_source = (count_d == '0) ? '0 : top_q.source;
    end

    // Keep a copy of the root entry in step with memory.
    top_d = top_q;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      top_d = mem_wdata_o;
    end
  end

  assign busy           = (state_q != kwm_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

[rtl/core/kway_merge_min_heap_core.sv]
// Top level of the k-way merge min-heap: controller and entry memory.
//
//   Channel  Direction  Handshake                 Word
//   -------  ---------  ------------------------  ------------------------------
//   command  in         start high, busy low      item_i  (cmd, value, source)
//   result   out        result_valid_o, 1 cycle   result_o (top, source, empty)
//
// Load is complete on acceptance and gives no result. Build, refill and drop
// with work to do stay busy through a fetch of the carried entry (build and
// drop), a compare per level walked, a write-back if the entry sinks to a leaf
// and a finish step, repeated per parent for build. The result word is
// registered. Reset clears the control state and entry count, not the entries.
// The receiver cannot stall: each result word is shown for one cycle only.
module kway_merge_min_heap_core #(
  parameter int unsigned HEAP_WAYS = kwm_pkg::HEAP_WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  kwm_pkg::item_t    item_i,
  output logic              result_valid_o,
  output kwm_pkg::result_t  result_o
);

  localparam int unsigned AW = $clog2(HEAP_WAYS);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  kwm_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_rd_a_addr;
  logic [AW-1:0]   mem_rd_b_addr;
  kwm_pkg::entry_t mem_rd_a_data;
  kwm_pkg::entry_t mem_rd_b_data;

  // Command sequencer.
  kwm_ctrl #(
    .HEAP_WAYS(HEAP_WAYS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_rd_a_addr_o (mem_rd_a_addr),
    .mem_rd_b_addr_o (mem_rd_b_addr),
    .mem_rd_a_data_i (mem_rd_a_data),
    .mem_rd_b_data_i (mem_rd_b_data)
  );

  // Heap entry store.
  kwm_mem #(
    .HEAP_WAYS(HEAP_WAYS)
  ) u_mem (
    .clk_i       (clk_i),
    .we_i        (mem_we),
    .waddr_i     (mem_waddr),
    .wdata_i     (mem_wdata),
    .rd_a_addr_i (mem_rd_a_addr),
    .rd_b_addr_i (mem_rd_b_addr),
    .rd_a_data_o (mem_rd_a_data),
    .rd_b_data_o (mem_rd_b_data)
  );

  // A result word only appears once the controller has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word shown while the controller is still busy");

  // An empty heap reports zero in the top fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.heap_empty) |->
      (result_o.top_value == '0) && (result_o.top_source == '0))
    else $error("empty heap result carries a non-zero top entry");

  // A load never produces a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.cmd == kwm_pkg::CMD_LOAD)) |=> !result_valid_o)
    else $error("load command produced a result word");

  // Memory writes stay inside the heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(HEAP_WAYS)))
    else $error("entry write outside the heap");

endmodule

[bench/kway_merge_min_heap_checker.sv]
// Checker for the k-way merge min-heap core: mirrors the heap and compares result words.
module kway_merge_min_heap_checker #(
  parameter int unsigned HEAP_WAYS = kwm_pkg::HEAP_WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  kwm_pkg::item_t    item_i,
  input  logic              result_valid_i,
  input  kwm_pkg::result_t  result_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  import kwm_pkg::*;

  // Mirror of the heap contents as the core should hold them.
  logic signed [VALUE_W-1:0]  mirror_val [HEAP_WAYS];
  logic        [SOURCE_W-1:0] mirror_src [HEAP_WAYS];
  int unsigned                mirror_cnt;

  // Result words still owed by the core, oldest first.
  result_t     owed_q [$];
  int unsigned mismatches;

  // Swap two heap slots in the mirror.
  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [VALUE_W-1:0]  tv;
    logic        [SOURCE_W-1:0] ts;
    tv = mirror_val[a];
    ts = mirror_src[a];
    mirror_val[a] = mirror_val[b];
    mirror_src[a] = mirror_src[b];
    mirror_val[b] = tv;
    mirror_src[b] = ts;
  endfunction

  // Push an entry towards the leaves. The left child is tried first, and a child
  // wins only when it is strictly smaller than the best value so far.
  function automatic void sink_entry(int unsigned pos);
    int unsigned least;
    int unsigned lchild;
    int unsigned rchild;
    while (pos < mirror_cnt) begin
      least  = pos;
      lchild = 2 * pos + 1;
      rchild = 2 * pos + 2;
      if (lchild < mirror_cnt && mirror_val[lchild] < mirror_val[least]) least = lchild;
      if (rchild < mirror_cnt && mirror_val[rchild] < mirror_val[least]) least = rchild;
      if (least == pos) break;
      swap_slots(pos, least);
      pos = least;
    end
  endfunction

  // The root as the core should report it; an empty heap shows zeros.
  function automatic result_t root_word();
    result_t w;
    w = '0;
    if (mirror_cnt == 0) begin
      w.heap_empty = 1'b1;
    end else begin
      w.top_value  = mirror_val[0];
      w.top_source = mirror_src[0];
    end
    return w;
  endfunction

  // Apply one accepted command word and queue the result it owes, if any.
  function automatic void apply_command(item_t w);
    int unsigned p;
    case (w.cmd)
      CMD_LOAD: begin
        if (mirror_cnt < HEAP_WAYS) begin
          mirror_val[mirror_cnt] = w.value;
          mirror_src[mirror_cnt] = w.source;
          mirror_cnt++;
        end
      end
      CMD_BUILD: begin
        for (p = mirror_cnt / 2; p > 0; p--) sink_entry(p - 1);
        owed_q.push_back(root_word());
      end
      CMD_REFILL: begin
        if (mirror_cnt > 0) begin
          mirror_val[0] = w.value;
          sink_entry(0);
        end
        owed_q.push_back(root_word());
      end
      default: begin
        if (mirror_cnt > 0) begin
          mirror_val[0] = mirror_val[mirror_cnt - 1];
          mirror_src[0] = mirror_src[mirror_cnt - 1];
          mirror_cnt--;
          sink_entry(0);
        end
        owed_q.push_back(root_word());
      end
    endcase
  endfunction

  // Compare any result word first, then take in a new command word: a result can
  // never belong to the command accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mirror_cnt = 0;
      owed_q.delete();
      mismatches = 0;
    end else begin
      if (result_valid_i) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: value %0d source %0d empty %0b",
                     result_i.top_value, result_i.top_source, result_i.heap_empty);
        end else begin
          want = owed_q.pop_front();
          if (result_i.top_value !== want.top_value ||
              result_i.top_source !== want.top_source ||
              result_i.heap_empty !== want.heap_empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected value %0d source %0d empty %0b, got value %0d source %0d empty %0b",
                       want.top_value, want.top_source, want.heap_empty,
                       result_i.top_value, result_i.top_source, result_i.heap_empty);
          end
        end
      end
      if (start_i && busy_i === 1'b0) apply_command(item_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= owed_q.size();
  end

endmodule

[bench/kway_merge_min_heap_core_test.sv]
// Top of the k-way merge min-heap test: clock, reset, command stimulus and verdict.
module kway_merge_min_heap_core_test;

  import kwm_pkg::*;

  localparam int unsigned WAYS        = HEAP_WAYS_DEF;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned CALM_FROM   = 1650;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN       = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       cmd_word;
  logic        res_valid;
  result_t     res_word;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned words_sent;
  int unsigned fill_level;
  int unsigned quiet_cycles;

  kway_merge_min_heap_core #(.HEAP_WAYS(WAYS)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (cmd_word),
    .result_valid_o(res_valid),
    .result_o      (res_word)
  );

  kway_merge_min_heap_checker #(.HEAP_WAYS(WAYS)) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (cmd_word),
    .result_valid_i(res_valid),
    .result_i      (res_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall watchdog: cycles in which neither a command nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || res_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Value for a load or refill: small values force ties, otherwise wide spread
  // with the extremes now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value(bit tie_heavy);
    int unsigned mode;
    mode = $urandom_range(0, 7);
    if (tie_heavy) return int'($urandom_range(0, 6)) - 3;
    if (mode == 0) return 32'sh7fffffff;
    if (mode == 1) return 32'sh80000000;
    return $urandom;
  endfunction

  // Present one command word and hold it until the core takes it. Entered and
  // left at a falling edge; an idle burst may come first in the earlier part.
  task automatic send_word(cmd_e cmd, logic signed [VALUE_W-1:0] value,
                           logic [SOURCE_W-1:0] source);
    item_t       w;
    int unsigned gap;
    w.cmd    = cmd;
    w.value  = value;
    w.source = source;
    if (words_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    cmd_word <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    words_sent++;
    if (cmd == CMD_LOAD && fill_level < WAYS) fill_level++;
    if (cmd == CMD_DROP && fill_level > 0) fill_level--;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned n_loads;
    int unsigned k;
    int unsigned pick;
    bit          ties;

    start      = 1'b0;
    cmd_word   = '0;
    rst_ni     = 1'b0;
    words_sent = 0;
    fill_level = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: commands on an empty heap.
    send_word(CMD_DROP,   $urandom, $urandom);
    send_word(CMD_REFILL, 32'sh7fffffff, 4'hf);
    send_word(CMD_BUILD,  $urandom, $urandom);
    // Extreme values, a tie on the minimum, then a drop before any build.
    send_word(CMD_LOAD,   32'sh7fffffff, 4'hf);
    send_word(CMD_LOAD,   32'sh80000000, 4'h0);
    send_word(CMD_LOAD,   32'sh00000000, 4'h5);
    send_word(CMD_LOAD,   -32'sd1,       4'ha);
    send_word(CMD_LOAD,   32'sh80000000, 4'h3);
    send_word(CMD_DROP,   $urandom, $urandom);
    send_word(CMD_BUILD,  $urandom, $urandom);
    send_word(CMD_REFILL, 32'sh7fffffff, $urandom);
    send_word(CMD_REFILL, 32'sh80000000, $urandom);
    send_word(CMD_REFILL, -32'sd1,       $urandom);
    // Drain to empty, through the last entry, and beyond.
    repeat (5) send_word(CMD_DROP, $urandom, $urandom);
    send_word(CMD_REFILL, 32'sd9, $urandom);
    // Loads with no build, then a refill on the unordered heap.
    send_word(CMD_LOAD,   32'sd5, 4'h1);
    send_word(CMD_LOAD,   32'sd3, 4'h2);
    send_word(CMD_REFILL, 32'sd7, $urandom);
    send_word(CMD_DROP,   $urandom, $urandom);
    send_word(CMD_DROP,   $urandom, $urandom);

    // Random merge rounds: load heads, build, then refill and drop until empty.
    while (words_sent < ITEM_TARGET) begin
      ties    = ($urandom_range(0, 3) == 0);
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(WAYS, WAYS + 4)
                                            : $urandom_range(1, WAYS);
      for (k = 0; k < n_loads; k++)
        send_word(CMD_LOAD, pick_value(ties),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : k[SOURCE_W-1:0]);
      // Now and then the build is left out, so the merge runs on stored order.
      if ($urandom_range(0, 9) != 0) send_word(CMD_BUILD, $urandom, $urandom);
      while (fill_level > 0 && words_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)      send_word(CMD_REFILL, pick_value(ties), $urandom);
        else if (pick < 95) send_word(CMD_DROP, $urandom, $urandom);
        else if (pick < 98) send_word(CMD_BUILD, $urandom, $urandom);
        else                send_word(CMD_LOAD, pick_value(ties), $urandom);
      end
      // Stray command on the emptied heap.
      if ($urandom_range(0, 3) == 0)
        send_word(cmd_e'($urandom_range(0, 3)), pick_value(1'b0), $urandom);
    end

    // Let the last results arrive, then allow for anything late.
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
